/* rtl/oqrk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// oqrk_pkg
// Shared word types, command and status codes, and the control and status
// bundles between the controller and the datapath of the ordered queue.
// ----------------------------------------------------------------------------
package oqrk_pkg;

    localparam int ID_W     = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READOUT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // input word
    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic signed [ID_W-1:0] id_value;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic signed [ID_W-1:0] entry_value;
        logic                   last;
        logic [FILL_W-1:0]      fill_count;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic                key_load;
        logic                idx_clr;
        logic                idx_inc;
        logic                mem_rd;
        logic                rd_next;
        logic                mem_wr;
        logic                wr_tail;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
        logic                out_entry;
        logic                out_last;
        logic [STATUS_W-1:0] out_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic idx_last;
        logic idx_pen;
        logic match;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

/* rtl/oqrk_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// oqrk_dpath
// Entry memory, fill count, scan index, key register and the output word
// register with its valid flag.
// ----------------------------------------------------------------------------
module oqrk_dpath #(
    parameter int CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire oqrk_pkg::t_in_word  i_in_word,
    input  wire oqrk_pkg::t_dp_cmd   i_cmd,
    output oqrk_pkg::t_dp_stat       o_stat,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output oqrk_pkg::t_out_word      o_out_word
);
    import oqrk_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ID_W-1:0]        mem [CAPACITY];
    logic [ID_W-1:0]        r_rd;
    logic signed [ID_W-1:0] r_key;
    logic [AW-1:0]          r_idx;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_vld;
    t_out_word              r_out;

    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [CW:0]   w_idx1;
    logic [CW:0]   w_idx2;
    logic [CW:0]   w_cnt;

    // scan position compares
    assign w_idx1 = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_idx2 = (CW+1)'(r_idx) + (CW+1)'(2);
    assign w_cnt  = (CW+1)'(r_count);

    assign w_rd_addr = i_cmd.rd_next ? (r_idx + AW'(1)) : r_idx;
    assign w_wr_addr = i_cmd.wr_tail ? r_count[AW-1:0] : r_idx;

    // next fill count
    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    // status back to the controller
    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(CAPACITY));
    assign o_stat.idx_last = (w_idx1 >= w_cnt);
    assign o_stat.idx_pen  = (w_idx2 >= w_cnt);
    assign o_stat.match    = (r_rd == r_key);
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[w_wr_addr] <= i_cmd.wr_tail ? r_key : r_rd;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= mem[w_rd_addr];
        end
    end

    // key and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_key <= i_in_word.id_value;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status      <= i_cmd.out_status;
            r_out.entry_value <= i_cmd.out_entry ? r_rd : '0;
            r_out.last        <= i_cmd.out_last;
            r_out.fill_count  <= FILL_W'(n_count);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

/* rtl/oqrk_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// oqrk_ctrl
// Command sequencer: append, linear search with shift-down removal, and
// entry-by-entry readout, issuing datapath commands each cycle.
// ----------------------------------------------------------------------------
module oqrk_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [oqrk_pkg::CMD_W-1:0]    i_command,
    output logic                               o_busy,
    input  wire oqrk_pkg::t_dp_stat            i_stat,
    output oqrk_pkg::t_dp_cmd                  o_cmd
);
    import oqrk_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_APPEND = 9'b000000010,
        S_SRD    = 9'b000000100,
        S_SCMP   = 9'b000001000,
        S_HRD    = 9'b000010000,
        S_HWR    = 9'b000100000,
        S_REPLY  = 9'b001000000,
        S_ORD    = 9'b010000000,
        S_OEMIT  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [STATUS_W-1:0] r_code,  n_code;
    logic                r_dec,   n_dec;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_dec   = r_dec;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.key_load = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_dec          = 1'b0;
                    case (i_command)
                        CMD_APPEND: begin
                            n_state = S_APPEND;
                        end
                        CMD_REMOVE: begin
                            if (i_stat.cnt_zero) begin
                                n_code  = ST_NOT_FOUND;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_SRD;
                            end
                        end
                        CMD_READOUT: begin
                            if (i_stat.cnt_zero) begin
                                n_code  = ST_EMPTY;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_ORD;
                            end
                        end
                        default: begin
                            n_code  = ST_DONE;
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.out_status = ST_FULL;
                    end else begin
                        o_cmd.mem_wr     = 1'b1;
                        o_cmd.wr_tail    = 1'b1;
                        o_cmd.cnt_inc    = 1'b1;
                        o_cmd.out_status = ST_DONE;
                    end
                    n_state = S_IDLE;
                end
            end
            // search: read one entry, compare the next cycle
            S_SRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                if (i_stat.match) begin
                    if (i_stat.idx_last) begin
                        n_code  = ST_DONE;
                        n_dec   = 1'b1;
                        n_state = S_REPLY;
                    end else begin
                        n_state = S_HRD;
                    end
                end else if (i_stat.idx_last) begin
                    n_code  = ST_NOT_FOUND;
                    n_state = S_REPLY;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            // close the gap: move each following entry down by one
            S_HRD: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_HWR;
            end
            S_HWR: begin
                o_cmd.mem_wr  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.idx_pen) begin
                    n_code  = ST_DONE;
                    n_dec   = 1'b1;
                    n_state = S_REPLY;
                end else begin
                    n_state = S_HRD;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = r_code;
                    o_cmd.cnt_dec    = r_dec;
                    n_state          = S_IDLE;
                end
            end
            // readout: one entry per read and emit pair
            S_ORD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_OEMIT;
            end
            S_OEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_entry  = 1'b1;
                    o_cmd.out_status = ST_ENTRY;
                    o_cmd.out_last   = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_DONE;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_dec   <= n_dec;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* rtl/ordered_queue_remove_by_key_unit.sv */
`default_nettype none
// Throughput: one word at a time; the next word is taken once the sequencer
// is back in idle. The single-port entry memory with registered read sets
// the per-entry pace. Output stall holds the sequencer where it emits.
// Reset: synchronous active low; queue empties, memory contents are not cleared.
// ----------------------------------------------------------------------------
// ordered_queue_remove_by_key_unit
// Bounded ordered queue of 32-bit identifiers with append at tail,
// remove of the first matching identifier, and full readout.
// ----------------------------------------------------------------------------
module ordered_queue_remove_by_key_unit #(
    parameter int CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire oqrk_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output oqrk_pkg::t_out_word      o_out_word
);
    import oqrk_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;

    // sequencer
    oqrk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_word.command),
        .o_busy     (w_busy),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage and output register
    oqrk_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = w_busy;

endmodule
`default_nettype wire
